@@ design/ifr_pkg.sv @@
// ----------------------------------------------------------------------------
// Image fragment reassembler package
// Shared constants, item types and the pixel packing function.
// ----------------------------------------------------------------------------
package ifr_pkg;

  localparam int FB_BYTES            = 16384;
  localparam int MAX_FRAGMENTS       = 32;
  localparam int PACKED_PER_FRAGMENT = 2044;
  localparam int HDR_LEN             = 8;

  localparam int PTR_W  = 17;
  localparam int SEQ_W  = 5;
  localparam int CNT_W  = 6;
  localparam int FILL_W = 4;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        fb_write;
    logic [15:0] fb_addr;
    logic [7:0]  fb_data;
    logic        fragment_ok;
    logic        image_complete;
    logic [31:0] current_image;
    logic        missing_known;
    logic [15:0] missing_count;
    logic [31:0] received_mask;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } step_t;

  // Four 2-bit pixels become four 1-bit pixels; a level of 2 or more is white.
  function automatic logic [3:0] pack_nibble(input logic [7:0] b);
    logic [3:0] nib;
    nib = 4'd0;
    for (int k = 0; k < 4; k++) begin
      nib[3 - k] = b[7 - 2 * k];
    end
    return nib;
  endfunction

endpackage

@@ design/ifr_in_if.sv @@
// ----------------------------------------------------------------------------
// Fragment event channel
// Valid/ready channel that carries one fragment event per item.
// ----------------------------------------------------------------------------
interface ifr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

@@ design/ifr_out_if.sv @@
// ----------------------------------------------------------------------------
// Reassembly result channel
// Valid/ready channel that carries one result item per fragment event.
// ----------------------------------------------------------------------------
interface ifr_out_if;
  logic        valid;
  logic        ready;
  logic        fb_write;
  logic [15:0] fb_addr;
  logic [7:0]  fb_data;
  logic        fragment_ok;
  logic        image_complete;
  logic [31:0] current_image;
  logic        missing_known;
  logic [15:0] missing_count;
  logic [31:0] received_mask;

  modport source (
    output valid, output fb_write, output fb_addr, output fb_data,
    output fragment_ok, output image_complete, output current_image,
    output missing_known, output missing_count, output received_mask,
    input ready
  );
  modport sink (
    input valid, input fb_write, input fb_addr, input fb_data,
    input fragment_ok, input image_complete, input current_image,
    input missing_known, input missing_count, input received_mask,
    output ready
  );
endinterface

@@ design/ifr_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted event until the core consumes it.
// ----------------------------------------------------------------------------
module ifr_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ifr_pkg::in_item_t in_item,
  input  logic              take,
  output ifr_pkg::step_t    held
);
  import ifr_pkg::*;

  logic     valid;
  in_item_t item;

  assign in_ready = !valid || take;
  assign held     = '{valid: valid, item: item};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ design/ifr_core.sv @@
// ----------------------------------------------------------------------------
// Reassembly core
// Holds the tracking state and computes one result item per event.
// ----------------------------------------------------------------------------
module ifr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ifr_pkg::in_item_t   item,
  output ifr_pkg::out_item_t  result
);
  import ifr_pkg::*;

  logic [31:0]       image_id, image_id_next;
  logic [15:0]       expected_total, expected_total_next;
  logic [31:0]       seen_mask, seen_mask_next;
  logic [CNT_W-1:0]  seen_count, seen_count_next;
  logic [7:0]        header_store [HDR_LEN];
  logic [FILL_W-1:0] header_fill, header_fill_next;
  logic [SEQ_W-1:0]  fragment_seq, fragment_seq_next;
  logic              fragment_good, fragment_good_next;
  logic [PTR_W-1:0]  write_pointer, write_pointer_next;
  logic [7:0]        held_byte, held_byte_next;
  logic              held_present, held_present_next;

  logic        header_wr;
  logic [31:0] hdr_id;
  logic [15:0] hdr_seq;
  logic [15:0] hdr_total;
  logic [31:0] seq_bit;
  logic [15:0] count_wide;

  assign hdr_id    = {header_store[0], header_store[1], header_store[2], header_store[3]};
  assign hdr_seq   = {header_store[4], header_store[5]};
  assign hdr_total = {header_store[6], item.data_byte};
  assign seq_bit   = 32'd1 << fragment_seq;

  always_comb begin
    image_id_next       = image_id;
    expected_total_next = expected_total;
    seen_mask_next      = seen_mask;
    seen_count_next     = seen_count;
    header_fill_next    = header_fill;
    fragment_seq_next   = fragment_seq;
    fragment_good_next  = fragment_good;
    write_pointer_next  = write_pointer;
    held_byte_next      = held_byte;
    held_present_next   = held_present;
    header_wr           = 1'b0;
    result              = '0;

    case (cmd_t'(item.cmd))
      CMD_BEGIN: begin
        header_fill_next   = '0;
        fragment_good_next = 1'b0;
        held_present_next  = 1'b0;
        write_pointer_next = '0;
      end
      CMD_DATA: begin
        if (header_fill < FILL_W'(HDR_LEN)) begin
          header_wr        = 1'b1;
          header_fill_next = header_fill + 1'b1;
          if (header_fill == FILL_W'(HDR_LEN - 1)) begin
            if (hdr_id < image_id) begin
              fragment_good_next = 1'b0;
            end else begin
              if (hdr_id > image_id) begin
                image_id_next       = hdr_id;
                expected_total_next = hdr_total;
                seen_mask_next      = '0;
                seen_count_next     = '0;
              end
              if (hdr_total > 16'(MAX_FRAGMENTS) || hdr_seq >= hdr_total) begin
                fragment_good_next = 1'b0;
              end else begin
                fragment_seq_next  = hdr_seq[SEQ_W-1:0];
                fragment_good_next = 1'b1;
                write_pointer_next = PTR_W'(PTR_W'(hdr_seq[SEQ_W-1:0]) *
                                            PTR_W'(PACKED_PER_FRAGMENT));
              end
            end
          end
        end else if (fragment_good) begin
          if (!held_present) begin
            held_byte_next    = item.data_byte;
            held_present_next = 1'b1;
          end else begin
            held_present_next = 1'b0;
            if (write_pointer < PTR_W'(FB_BYTES)) begin
              result.fb_write    = 1'b1;
              result.fb_addr     = write_pointer[15:0];
              result.fb_data     = {pack_nibble(held_byte), pack_nibble(item.data_byte)};
              write_pointer_next = write_pointer + 1'b1;
            end
          end
        end
      end
      CMD_END: begin
        if (fragment_good) begin
          result.fragment_ok = 1'b1;
          if ((seen_mask & seq_bit) == '0) begin
            seen_mask_next  = seen_mask | seq_bit;
            seen_count_next = seen_count + 1'b1;
          end
          result.image_complete = (expected_total != '0) &&
                                  (16'(seen_count_next) >= expected_total);
        end
      end
      CMD_RESET: begin
        image_id_next       = '0;
        expected_total_next = '0;
        seen_mask_next      = '0;
        seen_count_next     = '0;
        header_fill_next    = '0;
        fragment_good_next  = 1'b0;
        held_present_next   = 1'b0;
      end
      default: begin
      end
    endcase

    count_wide           = 16'(seen_count_next);
    result.current_image = image_id_next;
    result.received_mask = seen_mask_next;
    result.missing_known = (expected_total_next != '0);
    result.missing_count = (expected_total_next > count_wide) ?
                           (expected_total_next - count_wide) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_id       <= '0;
      expected_total <= '0;
      seen_mask      <= '0;
      seen_count     <= '0;
      header_fill    <= '0;
      fragment_seq   <= '0;
      fragment_good  <= 1'b0;
      write_pointer  <= '0;
      held_byte      <= '0;
      held_present   <= 1'b0;
    end else if (step) begin
      image_id       <= image_id_next;
      expected_total <= expected_total_next;
      seen_mask      <= seen_mask_next;
      seen_count     <= seen_count_next;
      header_fill    <= header_fill_next;
      fragment_seq   <= fragment_seq_next;
      fragment_good  <= fragment_good_next;
      write_pointer  <= write_pointer_next;
      held_byte      <= held_byte_next;
      held_present   <= held_present_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && header_wr) begin
      header_store[header_fill[2:0]] <= item.data_byte;
    end
  end

endmodule

@@ design/ifr_out_stage.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module ifr_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ifr_pkg::out_item_t result,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output ifr_pkg::out_item_t out_item
);
  import ifr_pkg::*;

  logic      valid;
  out_item_t data;

  assign free      = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
    if (free && load) begin
      data <= result;
    end
  end

endmodule

@@ design/image_fragment_reassembler.sv @@
// ----------------------------------------------------------------------------
// Image fragment reassembler
// Rebuilds a 1-bpp framebuffer image from a stream of fragment events.
// ----------------------------------------------------------------------------
// Every event gives exactly one result item, and one event is taken per clock
// cycle when the result side keeps up; an accepted event is held in the input
// register and its result in the result register. The rate is set by the update of
// the tracking state in the core, which sits between the two registers.
module image_fragment_reassembler (
  input logic         clk,
  input logic         rst,
  ifr_in_if.sink      in_ch,
  ifr_out_if.source   out_ch
);
  import ifr_pkg::*;

  in_item_t  in_item;
  step_t     held;
  out_item_t result;
  out_item_t out_item;
  logic      free;
  logic      step;

  assign in_item = '{cmd: in_ch.cmd, data_byte: in_ch.data_byte};
  assign step    = held.valid && free;

  ifr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .take     (step),
    .held     (held)
  );

  ifr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held.item),
    .result (result)
  );

  ifr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .result    (result),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.fb_write       = out_item.fb_write;
  assign out_ch.fb_addr        = out_item.fb_addr;
  assign out_ch.fb_data        = out_item.fb_data;
  assign out_ch.fragment_ok    = out_item.fragment_ok;
  assign out_ch.image_complete = out_item.image_complete;
  assign out_ch.current_image  = out_item.current_image;
  assign out_ch.missing_known  = out_item.missing_known;
  assign out_ch.missing_count  = out_item.missing_count;
  assign out_ch.received_mask  = out_item.received_mask;

endmodule

@@ design/ifr_checker.sv @@
// ----------------------------------------------------------------------------
// Reassembler port checker
// Checks result consistency and output stall behavior at the top-level ports.
// ----------------------------------------------------------------------------
module ifr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        fb_write,
  input logic [15:0] fb_addr,
  input logic [7:0]  fb_data,
  input logic        fragment_ok,
  input logic        image_complete,
  input logic        missing_known,
  input logic [15:0] missing_count,
  input logic [31:0] received_mask
);
  import ifr_pkg::*;

  a_idle_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fb_write |-> fb_addr == 16'd0 && fb_data == 8'd0)
    else $error("Result without a write carries address or data.");

  a_complete_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_complete |-> fragment_ok && !fb_write)
    else $error("Completion reported without a valid end of fragment.");

  a_unknown_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !missing_known |-> missing_count == 16'd0)
    else $error("Missing count is nonzero while the total is unknown.");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && fb_write |-> 17'(fb_addr) < 17'(FB_BYTES))
    else $error("Framebuffer write beyond the end of the buffer.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(received_mask) && $stable(fb_addr))
    else $error("Stalled result item changed.");

endmodule

bind image_fragment_reassembler ifr_checker u_ifr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .fb_write       (out_ch.fb_write),
  .fb_addr        (out_ch.fb_addr),
  .fb_data        (out_ch.fb_data),
  .fragment_ok    (out_ch.fragment_ok),
  .image_complete (out_ch.image_complete),
  .missing_known  (out_ch.missing_known),
  .missing_count  (out_ch.missing_count),
  .received_mask  (out_ch.received_mask)
);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Image fragment reassembler testbench
// Drives fragment events through the input channel: first a short table of
// events, then random fragments with random idle cycles on both channels. A
// predictor tracks the reassembly state, and each result item is checked field
// by field against the oldest expected item.
// ----------------------------------------------------------------------------
module testbench;
  import ifr_pkg::*;

  localparam int TOTAL_ITEMS  = 1450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data;
    bit         typed;
    out_item_t  want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  int   errors = 0;
  int   cycles = 0;
  int   sent = 0;
  bit   steady = 1'b0;

  out_item_t pending_results[$];
  plan_row_t plan[$];

  logic [31:0] trk_image;
  logic [15:0] trk_total;
  logic [31:0] trk_mask;
  logic [5:0]  trk_count;
  logic [7:0]  hdr_bytes [8];
  logic [3:0]  hdr_fill;
  logic [4:0]  frag_seq;
  logic        frag_good;
  logic [16:0] wr_ptr;
  logic [7:0]  held_byte;
  logic        held_valid;

  ifr_in_if  in_ch ();
  ifr_out_if out_ch ();

  image_fragment_reassembler u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [3:0] to_mono(logic [7:0] px);
    logic [3:0] mono;
    int k;
    for (k = 0; k < 4; k++) begin
      mono[3 - k] = (px[7 - 2 * k -: 2] >= 2'd2);
    end
    return mono;
  endfunction

  function automatic void clear_tracking();
    trk_image  = '0;
    trk_total  = '0;
    trk_mask   = '0;
    trk_count  = '0;
    hdr_fill   = '0;
    frag_good  = 1'b0;
    held_valid = 1'b0;
  endfunction

  function automatic out_item_t reassemble(cmd_t cmd, logic [7:0] data);
    out_item_t   res;
    logic [31:0] id;
    logic [15:0] seq;
    logic [15:0] total;
    res = '0;
    case (cmd)
      CMD_BEGIN: begin
        hdr_fill   = '0;
        frag_good  = 1'b0;
        held_valid = 1'b0;
        wr_ptr     = '0;
      end
      CMD_DATA: begin
        if (hdr_fill < HDR_LEN) begin
          hdr_bytes[hdr_fill[2:0]] = data;
          hdr_fill = hdr_fill + 4'd1;
          if (hdr_fill == HDR_LEN) begin
            id    = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
            seq   = {hdr_bytes[4], hdr_bytes[5]};
            total = {hdr_bytes[6], hdr_bytes[7]};
            if (id < trk_image) begin
              frag_good = 1'b0;
            end else begin
              // A newer image restarts tracking even when its own header is bad.
              if (id > trk_image) begin
                trk_image = id;
                trk_total = total;
                trk_mask  = '0;
                trk_count = '0;
              end
              if (total > MAX_FRAGMENTS || seq >= total) begin
                frag_good = 1'b0;
              end else begin
                frag_seq  = seq[4:0];
                frag_good = 1'b1;
                wr_ptr    = 17'(frag_seq * PACKED_PER_FRAGMENT);
              end
            end
          end
        end else if (frag_good) begin
          if (!held_valid) begin
            held_byte  = data;
            held_valid = 1'b1;
          end else begin
            held_valid = 1'b0;
            if (wr_ptr < FB_BYTES) begin
              res.fb_write = 1'b1;
              res.fb_addr  = wr_ptr[15:0];
              res.fb_data  = {to_mono(held_byte), to_mono(data)};
              wr_ptr       = wr_ptr + 17'd1;
            end
          end
        end
      end
      CMD_END: begin
        if (frag_good) begin
          res.fragment_ok = 1'b1;
          if (!trk_mask[frag_seq]) begin
            trk_mask[frag_seq] = 1'b1;
            trk_count = trk_count + 6'd1;
          end
          res.image_complete = (trk_total != 0) && (trk_count >= trk_total);
        end
      end
      CMD_RESET: begin
        clear_tracking();
      end
      default: begin
      end
    endcase
    res.current_image = trk_image;
    res.missing_known = (trk_total != 0);
    res.missing_count = (trk_total > trk_count) ? trk_total - trk_count : '0;
    res.received_mask = trk_mask;
    return res;
  endfunction

  function automatic out_item_t status_only(logic [31:0] image, logic [15:0] missing,
                                            logic [31:0] mask);
    out_item_t res;
    res = '0;
    res.current_image = image;
    res.missing_known = 1'b1;
    res.missing_count = missing;
    res.received_mask = mask;
    return res;
  endfunction

  function automatic plan_row_t row(cmd_t cmd, logic [7:0] data, bit typed = 1'b0,
                                    out_item_t want = '0);
    plan_row_t r;
    r.cmd   = cmd;
    r.data  = data;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result();
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result item arrived with no expected item pending");
      errors++;
    end else begin
      want = pending_results.pop_front();
      compare_field("fb_write", 32'(want.fb_write), 32'(out_ch.fb_write));
      compare_field("fb_addr", 32'(want.fb_addr), 32'(out_ch.fb_addr));
      compare_field("fb_data", 32'(want.fb_data), 32'(out_ch.fb_data));
      compare_field("fragment_ok", 32'(want.fragment_ok), 32'(out_ch.fragment_ok));
      compare_field("image_complete", 32'(want.image_complete), 32'(out_ch.image_complete));
      compare_field("current_image", want.current_image, out_ch.current_image);
      compare_field("missing_known", 32'(want.missing_known), 32'(out_ch.missing_known));
      compare_field("missing_count", 32'(want.missing_count), 32'(out_ch.missing_count));
      compare_field("received_mask", want.received_mask, out_ch.received_mask);
    end
  endfunction

  task automatic send_event(cmd_t cmd, logic [7:0] data, bit typed = 1'b0,
                            out_item_t want = '0);
    out_item_t predicted;
    while (!steady && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.data_byte <= data;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = reassemble(cmd, data);
    pending_results.push_back(typed ? want : predicted);
    sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_fragment();
    logic [31:0] id;
    logic [15:0] total;
    logic [15:0] seq;
    logic [63:0] header;
    int pick;
    int length;
    int i;
    pick = $urandom_range(99);
    if (pick < 65) id = trk_image;
    else if (pick < 80) id = trk_image + $urandom_range(1, 3);
    else if (pick < 90) id = trk_image - $urandom_range(1, 2);
    else if (pick < 96) id = $urandom;
    else id = 32'hFFFF_FFFF;
    pick = $urandom_range(99);
    if (pick < 70) total = 16'($urandom_range(1, 6));
    else if (pick < 80) total = 16'(MAX_FRAGMENTS);
    else if (pick < 87) total = '0;
    else if (pick < 94) total = 16'($urandom_range(MAX_FRAGMENTS + 1, MAX_FRAGMENTS + 4));
    else total = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    if (pick < 80) seq = (total == 0) ? '0 : 16'($urandom_range(total - 1));
    else if (pick < 92) seq = total + 16'($urandom_range(2));
    else seq = 16'($urandom_range(16'hFFFF));
    length = $urandom_range(9);
    // A long fragment at sequence 8 runs past the end of the framebuffer.
    if ($urandom_range(99) < 5) begin
      total  = 16'($urandom_range(9, MAX_FRAGMENTS));
      seq    = 16'd8;
      length = $urandom_range(66, 90);
    end
    header = {id, seq, total};
    send_event(CMD_BEGIN, 8'($urandom_range(255)));
    for (i = 0; i < HDR_LEN; i++) begin
      send_event(CMD_DATA, header[63 - 8 * i -: 8]);
    end
    for (i = 0; i < length; i++) begin
      send_event(CMD_DATA, 8'($urandom_range(255)));
    end
    send_event(CMD_END, 8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_event(CMD_END, 8'($urandom_range(255)));
    end else if (pick < 25) begin
      repeat ($urandom_range(1, 3)) send_event(CMD_DATA, 8'($urandom_range(255)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
      out_ch.ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int  pick;
    bit  paused;
    paused = 1'b0;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_BEGIN;
    in_ch.data_byte <= 8'h00;
    clear_tracking();
    frag_seq  = '0;
    wr_ptr    = '0;
    held_byte = '0;

    // Image 5, sequence 0 of 2, then a stale header for image 4.
    plan.push_back(row(CMD_END, 8'h00, 1'b1, '0));
    plan.push_back(row(CMD_BEGIN, 8'h00, 1'b1, '0));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h05));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h02, 1'b1, status_only(32'd5, 16'd2, 32'd0)));
    plan.push_back(row(CMD_DATA, 8'hAA));
    plan.push_back(row(CMD_DATA, 8'h55));
    plan.push_back(row(CMD_DATA, 8'hFF));
    plan.push_back(row(CMD_DATA, 8'hFF));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h12));
    plan.push_back(row(CMD_END, 8'hFF));
    plan.push_back(row(CMD_END, 8'h00));
    plan.push_back(row(CMD_DATA, 8'hC0));
    plan.push_back(row(CMD_BEGIN, 8'hFF));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h04));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h01));
    plan.push_back(row(CMD_DATA, 8'h00));
    plan.push_back(row(CMD_DATA, 8'h02));
    plan.push_back(row(CMD_END, 8'h00, 1'b1, status_only(32'd5, 16'd1, 32'd1)));
    plan.push_back(row(CMD_RESET, 8'hFF, 1'b1, '0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_event(plan[i].cmd, plan[i].data, plan[i].typed, plan[i].want);
    end
    wait_drained();

    while (sent < TOTAL_ITEMS) begin
      steady = (sent >= 500 && sent < 800);
      if (!paused && sent >= 900) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 84) begin
        send_fragment();
      end else if (pick < 90) begin
        send_event(CMD_BEGIN, 8'($urandom_range(255)));
        repeat ($urandom_range(7)) send_event(CMD_DATA, 8'($urandom_range(255)));
      end else if (pick < 93) begin
        send_event(CMD_RESET, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_event(cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
